/* hdl/ctcg_pkg.sv */
// ctcg_pkg: widths, codes and shared types of the ctc greedy decoder
// no dependencies; imported by every module of the decoder
`timescale 1ns / 1ps

package ctcg_pkg;

    // field widths
    localparam int SCORE_W   = 16;
    localparam int INDEX_W   = 13;
    localparam int POS_W     = 13;
    localparam int CFG_W     = 14;
    localparam int SUM_W     = 27;
    localparam int COUNT_W   = 11;
    localparam int IN_DATA_W  = 16;
    localparam int OUT_DATA_W = 56;

    // limits and reset values
    localparam int MIN_CLASSES   = 2;
    localparam int MAX_CLASSES   = 8192;
    localparam int MAX_STEPS     = 1024;
    localparam int RESET_CLASSES = 6625;

    localparam logic [SUM_W-1:0]   SUM_MAX   = {SUM_W{1'b1}};
    localparam logic [SCORE_W-1:0] SCORE_MAX = {SCORE_W{1'b1}};

    // divider
    localparam int DIV_STEP_W = 5;
    localparam int REM_W      = COUNT_W - 1;

    // queue between front and back
    localparam int QUEUE_DEPTH = 4;
    localparam int QPTR_W      = 2;
    localparam int QCNT_W      = 3;

    // result kinds
    localparam logic KIND_CHAR    = 1'b0;
    localparam logic KIND_SUMMARY = 1'b1;

    typedef enum logic [0:0] {
        BK_FETCH,
        BK_DIVIDE
    } back_state_t;

    // one queued job for the back end
    typedef struct packed {
        logic               kind;
        logic [INDEX_W-1:0] class_index;
        logic [SCORE_W-1:0] char_score;
        logic [SUM_W-1:0]   score_sum;
        logic [COUNT_W-1:0] char_count;
        logic               last;
    } entry_t;

    // up to two jobs pushed by one score beat
    typedef struct packed {
        logic [1:0] count;
        entry_t     first;
        entry_t     second;
    } push_t;

endpackage

/* hdl/ctcg_front.sv */
// ctcg_front: per-frame argmax, collapse of repeats and blanks, score accumulation
// depends on ctcg_pkg; feeds jobs to ctcg_queue
`timescale 1ns / 1ps

module ctcg_front (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic [ctcg_pkg::CFG_W-1:0]    num_classes,
    input  logic                          s_valid,
    output logic                          s_ready,
    input  logic [ctcg_pkg::SCORE_W-1:0]  s_score,
    input  logic                          s_eos,
    input  logic                          q_room,
    output ctcg_pkg::push_t               push
);
    import ctcg_pkg::*;

    logic [POS_W-1:0]   pos_reg,   pos_next;
    logic [SCORE_W-1:0] best_reg,  best_next;
    logic [INDEX_W-1:0] idx_reg,   idx_next;
    logic [INDEX_W-1:0] prev_reg,  prev_next;
    logic [SUM_W-1:0]   sum_reg,   sum_next;
    logic [COUNT_W-1:0] cnt_reg,   cnt_next;

    logic               fire;
    logic [CFG_W-1:0]   n_clamped;
    logic [CFG_W-1:0]   last_pos;
    logic [SCORE_W-1:0] cand_score;
    logic [INDEX_W-1:0] cand_idx;
    logic               close;
    logic               emit;
    logic [SUM_W:0]     sum_wide;
    logic [SUM_W-1:0]   sum_upd;
    logic [COUNT_W-1:0] cnt_upd;
    entry_t             e_char;
    entry_t             e_sum;

    assign s_ready = q_room;
    assign fire    = s_valid & q_room;

    // class count clamped to the supported range
    always_comb
    begin
        if (num_classes < CFG_W'(MIN_CLASSES))
            n_clamped = CFG_W'(MIN_CLASSES);
        else if (num_classes > CFG_W'(MAX_CLASSES))
            n_clamped = CFG_W'(MAX_CLASSES);
        else
            n_clamped = num_classes;
        last_pos = n_clamped - CFG_W'(1);
    end

    always_comb
    begin
        // first score of a frame always takes the lead at the blank index
        if (pos_reg == '0)
        begin
            cand_score = s_score;
            cand_idx   = '0;
        end
        else if (s_score > best_reg)
        begin
            cand_score = s_score;
            cand_idx   = pos_reg;
        end
        else
        begin
            cand_score = best_reg;
            cand_idx   = idx_reg;
        end

        close = ({1'b0, pos_reg} >= last_pos) || s_eos;
        emit  = close && (cand_idx != '0) && (cand_idx != prev_reg);

        sum_wide = {1'b0, sum_reg} + {{(SUM_W + 1 - SCORE_W){1'b0}}, cand_score};
        if (!emit)
            sum_upd = sum_reg;
        else if (sum_wide[SUM_W])
            sum_upd = SUM_MAX;
        else
            sum_upd = sum_wide[SUM_W-1:0];

        if (emit && (cnt_reg < COUNT_W'(MAX_STEPS)))
            cnt_upd = cnt_reg + COUNT_W'(1);
        else
            cnt_upd = cnt_reg;

        e_char.kind        = KIND_CHAR;
        e_char.class_index = cand_idx;
        e_char.char_score  = cand_score;
        e_char.score_sum   = '0;
        e_char.char_count  = '0;
        e_char.last        = ~s_eos;

        e_sum.kind        = KIND_SUMMARY;
        e_sum.class_index = '0;
        e_sum.char_score  = '0;
        e_sum.score_sum   = sum_upd;
        e_sum.char_count  = cnt_upd;
        e_sum.last        = 1'b1;

        push.first  = emit ? e_char : e_sum;
        push.second = e_sum;
        if (!fire)
            push.count = 2'd0;
        else if (emit && s_eos)
            push.count = 2'd2;
        else if (emit || s_eos)
            push.count = 2'd1;
        else
            push.count = 2'd0;
    end

    always_comb
    begin
        pos_next  = pos_reg;
        best_next = best_reg;
        idx_next  = idx_reg;
        prev_next = prev_reg;
        sum_next  = sum_reg;
        cnt_next  = cnt_reg;
        if (fire)
        begin
            if (close)
            begin
                prev_next = cand_idx;
                pos_next  = '0;
                best_next = '0;
                idx_next  = '0;
            end
            else
            begin
                pos_next  = pos_reg + POS_W'(1);
                best_next = cand_score;
                idx_next  = cand_idx;
            end
            if (s_eos)
            begin
                prev_next = '0;
                sum_next  = '0;
                cnt_next  = '0;
            end
            else
            begin
                sum_next = sum_upd;
                cnt_next = cnt_upd;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pos_reg  <= '0;
            best_reg <= '0;
            idx_reg  <= '0;
            prev_reg <= '0;
            sum_reg  <= '0;
            cnt_reg  <= '0;
        end
        else
        begin
            pos_reg  <= pos_next;
            best_reg <= best_next;
            idx_reg  <= idx_next;
            prev_reg <= prev_next;
            sum_reg  <= sum_next;
            cnt_reg  <= cnt_next;
        end
    end

    // an end-of-sequence beat always queues its summary
    a_eos_pushes: assert property (@(posedge clk) disable iff (!rst_n)
        (fire && s_eos) |-> (push.count != 2'd0))
        else $error("end-of-sequence beat queued no summary");

endmodule

/* hdl/ctcg_queue.sv */
// ctcg_queue: short job queue between front and back, up to two pushes and one pop per cycle
// depends on ctcg_pkg
`timescale 1ns / 1ps

module ctcg_queue (
    input  logic                 clk,
    input  logic                 rst_n,
    input  ctcg_pkg::push_t      push,
    output logic                 room,
    input  logic                 pop,
    output logic                 head_valid,
    output ctcg_pkg::entry_t     head
);
    import ctcg_pkg::*;

    entry_t             store [QUEUE_DEPTH];
    logic [QPTR_W-1:0]  wr_ptr_reg, wr_ptr_next;
    logic [QPTR_W-1:0]  rd_ptr_reg, rd_ptr_next;
    logic [QCNT_W-1:0]  cnt_reg,    cnt_next;
    logic               do_pop;
    logic [QPTR_W-1:0]  wr_ptr_1;

    // room for the worst case of two jobs from one beat
    assign room       = (cnt_reg <= QCNT_W'(QUEUE_DEPTH - 2));
    assign head_valid = (cnt_reg != '0);
    assign head       = store[rd_ptr_reg];
    assign do_pop     = pop & head_valid;
    assign wr_ptr_1   = wr_ptr_reg + QPTR_W'(1);

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg + QPTR_W'(push.count);
        rd_ptr_next = rd_ptr_reg + QPTR_W'(do_pop);
        cnt_next    = cnt_reg + QCNT_W'(push.count) - QCNT_W'(do_pop);
    end

    always_ff @(posedge clk)
    begin
        if (push.count != 2'd0)
            store[wr_ptr_reg] <= push.first;
        if (push.count == 2'd2)
            store[wr_ptr_1] <= push.second;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg    <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            cnt_reg    <= cnt_next;
        end
    end

    a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
        ({1'b0, cnt_reg} + {2'b00, push.count}) <= (QCNT_W + 1)'(QUEUE_DEPTH))
        else $error("job queue overflow");

    a_pop_tracks: assert property (@(posedge clk) disable iff (!rst_n)
        (do_pop && push.count == 2'd0) |=> (cnt_reg == $past(cnt_reg) - QCNT_W'(1)))
        else $error("queue fill count out of step with pops");

endmodule

/* hdl/ctcg_divider.sv */
// ctcg_divider: restoring divider, one quotient bit per cycle, saturated to a score
// depends on ctcg_pkg; used by ctcg_back for the sequence average
`timescale 1ns / 1ps

module ctcg_divider (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          start,
    input  logic [ctcg_pkg::SUM_W-1:0]    dividend,
    input  logic [ctcg_pkg::COUNT_W-1:0]  divisor,
    output logic                          busy,
    output logic [ctcg_pkg::SCORE_W-1:0]  quotient
);
    import ctcg_pkg::*;

    logic                  busy_reg, busy_next;
    logic [DIV_STEP_W-1:0] step_reg, step_next;
    logic [REM_W-1:0]      rem_reg,  rem_next;
    logic [SUM_W-1:0]      quot_reg, quot_next;
    logic [COUNT_W-1:0]    div_reg,  div_next;
    logic [COUNT_W-1:0]    trial;
    logic                  ge;
    logic [COUNT_W-1:0]    diff;

    // divisor is at most MAX_STEPS, so the remainder fits REM_W bits
    assign trial = {rem_reg, quot_reg[SUM_W-1]};
    assign ge    = (trial >= div_reg);
    assign diff  = trial - div_reg;

    always_comb
    begin
        busy_next = busy_reg;
        step_next = step_reg;
        rem_next  = rem_reg;
        quot_next = quot_reg;
        div_next  = div_reg;
        if (start)
        begin
            busy_next = 1'b1;
            step_next = DIV_STEP_W'(SUM_W - 1);
            rem_next  = '0;
            quot_next = dividend;
            div_next  = divisor;
        end
        else if (busy_reg)
        begin
            rem_next  = ge ? diff[REM_W-1:0] : trial[REM_W-1:0];
            quot_next = {quot_reg[SUM_W-2:0], ge};
            step_next = step_reg - DIV_STEP_W'(1);
            if (step_reg == '0)
                busy_next = 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        step_reg <= step_next;
        rem_reg  <= rem_next;
        quot_reg <= quot_next;
        div_reg  <= div_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            busy_reg <= 1'b0;
        else
            busy_reg <= busy_next;
    end

    assign busy     = busy_reg;
    // quotients above the score range saturate
    assign quotient = (quot_reg[SUM_W-1:SCORE_W] != '0) ? SCORE_MAX : quot_reg[SCORE_W-1:0];

endmodule

/* hdl/ctcg_back.sv */
// ctcg_back: takes queued jobs, runs the average division and fills the output register
// depends on ctcg_pkg and ctcg_divider
`timescale 1ns / 1ps

module ctcg_back (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          head_valid,
    input  ctcg_pkg::entry_t              head,
    output logic                          pop,
    output logic                          m_valid,
    input  logic                          m_ready,
    output logic                          m_kind,
    output logic [ctcg_pkg::INDEX_W-1:0]  m_class_index,
    output logic [ctcg_pkg::SCORE_W-1:0]  m_char_score,
    output logic [ctcg_pkg::SCORE_W-1:0]  m_average_score,
    output logic [ctcg_pkg::COUNT_W-1:0]  m_char_count,
    output logic                          m_last
);
    import ctcg_pkg::*;

    back_state_t        state_reg, state_next;
    logic [COUNT_W-1:0] held_cnt_reg, held_cnt_next;

    logic               out_valid_reg;
    logic               out_kind_reg;
    logic [INDEX_W-1:0] out_idx_reg;
    logic [SCORE_W-1:0] out_cs_reg;
    logic [SCORE_W-1:0] out_avg_reg;
    logic [COUNT_W-1:0] out_cnt_reg;
    logic               out_last_reg;

    logic               out_free;
    logic               div_start;
    logic               div_busy;
    logic [SCORE_W-1:0] div_quot;
    logic               load;
    logic               ld_kind;
    logic [INDEX_W-1:0] ld_idx;
    logic [SCORE_W-1:0] ld_cs;
    logic [SCORE_W-1:0] ld_avg;
    logic [COUNT_W-1:0] ld_cnt;
    logic               ld_last;
    logic               needs_div;

    assign out_free  = ~out_valid_reg | m_ready;
    assign needs_div = (head.kind == KIND_SUMMARY) && (head.char_count != '0);

    ctcg_divider u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .dividend (head.score_sum),
        .divisor  (head.char_count),
        .busy     (div_busy),
        .quotient (div_quot)
    );

    // next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            BK_FETCH:
            begin
                if (head_valid && out_free && needs_div)
                    state_next = BK_DIVIDE;
            end
            BK_DIVIDE:
            begin
                if (!div_busy && out_free)
                    state_next = BK_FETCH;
            end
            default:
                state_next = BK_FETCH;
        endcase
    end

    // outputs of the sequencer
    always_comb
    begin
        pop           = 1'b0;
        div_start     = 1'b0;
        load          = 1'b0;
        held_cnt_next = held_cnt_reg;
        ld_kind       = head.kind;
        ld_idx        = head.class_index;
        ld_cs         = head.char_score;
        ld_avg        = '0;
        ld_cnt        = head.char_count;
        ld_last       = head.last;
        case (state_reg)
            BK_FETCH:
            begin
                if (head_valid && out_free)
                begin
                    pop = 1'b1;
                    if (needs_div)
                    begin
                        div_start     = 1'b1;
                        held_cnt_next = head.char_count;
                    end
                    else
                        load = 1'b1;
                end
            end
            BK_DIVIDE:
            begin
                ld_kind = KIND_SUMMARY;
                ld_idx  = '0;
                ld_cs   = '0;
                ld_avg  = div_quot;
                ld_cnt  = held_cnt_reg;
                ld_last = 1'b1;
                if (!div_busy && out_free)
                    load = 1'b1;
            end
            default:
            begin
                load = 1'b0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= BK_FETCH;
            held_cnt_reg  <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg    <= state_next;
            held_cnt_reg <= held_cnt_next;
            if (load)
                out_valid_reg <= 1'b1;
            else if (m_ready)
                out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            out_kind_reg <= ld_kind;
            out_idx_reg  <= ld_idx;
            out_cs_reg   <= ld_cs;
            out_avg_reg  <= ld_avg;
            out_cnt_reg  <= ld_cnt;
            out_last_reg <= ld_last;
        end
    end

    assign m_valid         = out_valid_reg;
    assign m_kind          = out_kind_reg;
    assign m_class_index   = out_idx_reg;
    assign m_char_score    = out_cs_reg;
    assign m_average_score = out_avg_reg;
    assign m_char_count    = out_cnt_reg;
    assign m_last          = out_last_reg;

    a_start_idle: assert property (@(posedge clk) disable iff (!rst_n)
        div_start |-> (state_reg == BK_FETCH && !div_busy && head_valid))
        else $error("divider started while busy or without a job");

endmodule

/* hdl/ctc_greedy_decoder_core.sv */
// ctc_greedy_decoder_core: top level of the ctc greedy decoder
// path: a character passes through the job queue and the output register after the beat that closes its frame;
//   a summary with a nonzero count also waits for the bit-serial divider in between
// throughput: one score beat per cycle while the job queue has room; each such summary holds the back end
//   while the divider runs, absorbed by the 4-entry job queue until it fills
// reset (rst_n, async, active low): class count 6625, all sequence state and queue cleared
`timescale 1ns / 1ps

module ctc_greedy_decoder_core (
    input  logic                              clk,
    input  logic                              rst_n,
    // class count register
    input  logic                              cfg_we,
    input  logic [ctcg_pkg::CFG_W-1:0]        cfg_wdata,
    // score stream
    input  logic                              s_axis_tvalid,
    output logic                              s_axis_tready,
    input  logic [ctcg_pkg::IN_DATA_W-1:0]    s_axis_tdata,   // [15:0] score
    input  logic                              s_axis_tlast,   // end of sequence
    // result stream
    output logic                              m_axis_tvalid,
    input  logic                              m_axis_tready,
    output logic [ctcg_pkg::OUT_DATA_W-1:0]   m_axis_tdata,   // [12:0] class_index,
                                                              // [28:13] char_score,
                                                              // [44:29] average_score,
                                                              // [55:45] char_count
    output logic [0:0]                        m_axis_tuser,   // [0] kind
    output logic                              m_axis_tlast    // last result of the beat
);
    import ctcg_pkg::*;

    logic [CFG_W-1:0]   cfg_reg;

    push_t              push;
    logic               q_room;
    logic               q_pop;
    logic               q_head_valid;
    entry_t             q_head;

    logic               out_kind;
    logic [INDEX_W-1:0] out_idx;
    logic [SCORE_W-1:0] out_cs;
    logic [SCORE_W-1:0] out_avg;
    logic [COUNT_W-1:0] out_cnt;

    // class count; the user must write it only while the decoder is idle, the block itself does not enforce this
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            cfg_reg <= CFG_W'(RESET_CLASSES);
        else if (cfg_we)
            cfg_reg <= cfg_wdata;
    end

    // front: argmax per frame, repeat/blank collapse, running sum and count
    ctcg_front u_front (
        .clk         (clk),
        .rst_n       (rst_n),
        .num_classes (cfg_reg),
        .s_valid     (s_axis_tvalid),
        .s_ready     (s_axis_tready),
        .s_score     (s_axis_tdata[SCORE_W-1:0]),
        .s_eos       (s_axis_tlast),
        .q_room      (q_room),
        .push        (push)
    );

    // jobs waiting for the back end
    ctcg_queue u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (push),
        .room       (q_room),
        .pop        (q_pop),
        .head_valid (q_head_valid),
        .head       (q_head)
    );

    // back: average division and the output register
    ctcg_back u_back (
        .clk             (clk),
        .rst_n           (rst_n),
        .head_valid      (q_head_valid),
        .head            (q_head),
        .pop             (q_pop),
        .m_valid         (m_axis_tvalid),
        .m_ready         (m_axis_tready),
        .m_kind          (out_kind),
        .m_class_index   (out_idx),
        .m_char_score    (out_cs),
        .m_average_score (out_avg),
        .m_char_count    (out_cnt),
        .m_last          (m_axis_tlast)
    );

    // pack result fields, lowest field first
    assign m_axis_tdata = {out_cnt, out_avg, out_cs, out_idx};
    assign m_axis_tuser = out_kind;

endmodule

/* tb/tb_ctc_greedy_decoder_core.sv */
// tb_ctc_greedy_decoder_core: self-checking testbench of the ctc greedy decoder core
// drives score beats and class-count writes, predicts every character and summary itself
// depends on hdl/ctcg_pkg.sv and hdl/ctc_greedy_decoder_core.sv
`timescale 1ns / 1ps

module tb_ctc_greedy_decoder_core;

    import ctcg_pkg::*;

    localparam int HALF_PERIOD  = 4;
    localparam int RESET_CYCLES = 10;
    localparam int CYCLE_LIMIT  = 1000000;
    localparam int DRAIN_CYCLES = 40;
    localparam int HOLD_CYCLES  = 400;
    localparam int RANDOM_BEATS = 450;
    localparam int QUIET_BEATS  = 80;
    localparam int MAX_REPORTS  = 10;

    // result beat layout, lowest bit up
    localparam int SCORE_LO = INDEX_W;
    localparam int AVG_LO   = INDEX_W + SCORE_W;
    localparam int COUNT_LO = INDEX_W + 2 * SCORE_W;

    typedef struct packed {
        logic               kind;
        logic [INDEX_W-1:0] class_index;
        logic [SCORE_W-1:0] char_score;
        logic [SCORE_W-1:0] average_score;
        logic [COUNT_W-1:0] char_count;
        logic               last;
    } decode_result_t;

    localparam decode_result_t NO_RESULT = '0;

    typedef enum logic [0:0] {
        ROW_WRITE,
        ROW_SCORE
    } row_kind_t;

    // one row of the directed part: a register write or a score beat,
    // optionally with the results typed in by hand
    typedef struct packed {
        row_kind_t      kind;
        logic [15:0]    value;
        logic           eos;
        logic [1:0]     typed_n;
        decode_result_t typed_a;
        decode_result_t typed_b;
    } stim_row_t;

    logic                  clk;
    logic                  rst_n;
    logic                  cfg_we;
    logic [CFG_W-1:0]      cfg_wdata;
    logic                  s_axis_tvalid;
    logic                  s_axis_tready;
    logic [IN_DATA_W-1:0]  s_axis_tdata;   // [15:0] score
    logic                  s_axis_tlast;   // end of sequence
    logic                  m_axis_tvalid;
    logic                  m_axis_tready;
    logic [OUT_DATA_W-1:0] m_axis_tdata;   // [12:0] class_index, [28:13] char_score,
                                           // [44:29] average_score, [55:45] char_count
    logic [0:0]            m_axis_tuser;   // [0] kind
    logic                  m_axis_tlast;

    // decoder state as the testbench sees it
    logic [CFG_W-1:0]   dec_classes;
    logic [POS_W-1:0]   dec_pos;
    logic [SCORE_W-1:0] dec_best;
    logic [INDEX_W-1:0] dec_best_idx;
    logic [INDEX_W-1:0] dec_prev_idx;
    logic [SUM_W-1:0]   dec_sum;
    logic [COUNT_W-1:0] dec_count;

    decode_result_t decoded_q [$];   // characters and summaries still to come out
    decode_result_t typed_q [$];     // hand-written results for the next directed beat
    stim_row_t      directed_rows [$];

    int  failures          = 0;
    int  beats_sent        = 0;
    int  chars_checked     = 0;
    int  summaries_checked = 0;
    int  cycle_count       = 0;
    bit  sender_idles      = 1'b1;
    bit  quiet_tail        = 1'b0;
    bit  hold_request      = 1'b0;
    logic hold_off         = 1'b0;
    int  ready_gap         = 0;

    ctc_greedy_decoder_core uut (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_we        (cfg_we),
        .cfg_wdata     (cfg_wdata),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tlast  (s_axis_tlast),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .m_axis_tlast  (m_axis_tlast)
    );

    always
    begin
        #(HALF_PERIOD) clk = 1'b1;
        #(HALF_PERIOD) clk = 1'b0;
    end

    // watchdog
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT)
        begin
            $display("timeout after %0d cycles, %0d results outstanding",
                     CYCLE_LIMIT, decoded_q.size());
            $display("tb_ctc_greedy_decoder_core NOT OK");
            $finish;
        end
    end

    function automatic decode_result_t char_result(input logic [INDEX_W-1:0] idx,
                                                   input logic [SCORE_W-1:0] score,
                                                   input logic last);
        decode_result_t r;
        r = NO_RESULT;
        r.kind        = KIND_CHAR;
        r.class_index = idx;
        r.char_score  = score;
        r.last        = last;
        return r;
    endfunction

    function automatic decode_result_t summary_result(input logic [SCORE_W-1:0] avg,
                                                      input logic [COUNT_W-1:0] count);
        decode_result_t r;
        r = NO_RESULT;
        r.kind          = KIND_SUMMARY;
        r.average_score = avg;
        r.char_count    = count;
        r.last          = 1'b1;
        return r;
    endfunction

    function automatic string show(input decode_result_t r);
        return $sformatf("kind=%0d idx=%0d score=%0d avg=%0d count=%0d last=%0d",
                         r.kind, r.class_index, r.char_score, r.average_score,
                         r.char_count, r.last);
    endfunction

    // class count in effect: the register clamped to the supported range
    function automatic int unsigned frame_length();
        int unsigned n;
        n = dec_classes;
        if (n < MIN_CLASSES)
            n = MIN_CLASSES;
        if (n > MAX_CLASSES)
            n = MAX_CLASSES;
        return n;
    endfunction

    task automatic note_failure(input string msg);
        failures++;
        if (failures <= MAX_REPORTS)
            $display("[%0t] %s", $time, msg);
    endtask

    // append one prediction to the pending results
    task automatic queue_result(input decode_result_t r);
        decoded_q = {decoded_q, r};
    endtask

    // append one row to the directed table
    task automatic add_row(input stim_row_t row);
        directed_rows = {directed_rows, row};
    endtask

    task automatic clear_utterance();
        dec_pos      = '0;
        dec_best     = '0;
        dec_best_idx = '0;
        dec_prev_idx = '0;
        dec_sum      = '0;
        dec_count    = '0;
    endtask

    // greedy ctc step: running argmax within the frame, emit on frame close
    // unless blank or a repeat, summary with saturating average on end of sequence
    task automatic ctc_decode_score(input logic [SCORE_W-1:0] score, input logic eos);
        int unsigned        n;
        logic [SUM_W:0]     grown;
        logic [SUM_W-1:0]   quotient;
        logic [SCORE_W-1:0] avg;
        n = frame_length();
        if (dec_pos == 0)
        begin
            dec_best     = score;
            dec_best_idx = '0;
        end
        else if (score > dec_best)
        begin
            dec_best     = score;
            dec_best_idx = dec_pos;
        end

        // frame closes at its last class, past it after a shrinking write, or on eos
        if (dec_pos >= n - 1 || eos)
        begin
            if (dec_best_idx != 0 && dec_best_idx != dec_prev_idx)
            begin
                grown   = {1'b0, dec_sum} + {{(SUM_W + 1 - SCORE_W){1'b0}}, dec_best};
                dec_sum = (grown > SUM_MAX) ? SUM_MAX : grown[SUM_W-1:0];
                if (dec_count < MAX_STEPS)
                    dec_count++;
                queue_result(char_result(dec_best_idx, dec_best, !eos));
            end
            dec_prev_idx = dec_best_idx;
            dec_pos      = '0;
            dec_best     = '0;
            dec_best_idx = '0;
        end
        else
            dec_pos = dec_pos + 1'b1;

        if (eos)
        begin
            avg = '0;
            if (dec_count != 0)
            begin
                quotient = dec_sum / dec_count;
                avg = (quotient > SCORE_MAX) ? SCORE_MAX : quotient[SCORE_W-1:0];
            end
            queue_result(summary_result(avg, dec_count));
            clear_utterance();
        end
    endtask

    // offer one score beat, with an occasional idle burst ahead of it
    task automatic push_score(input logic [SCORE_W-1:0] score, input logic eos);
        int mark;
        @(negedge clk);
        if (sender_idles && $urandom_range(0, 5) == 0)
        begin
            s_axis_tvalid <= 1'b0;
            repeat ($urandom_range(1, 10)) @(negedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= score;
        s_axis_tlast  <= eos;
        @(posedge clk);
        while (!s_axis_tready)
            @(posedge clk);
        mark = decoded_q.size();
        ctc_decode_score(score, eos);
        // directed rows with typed results replace what was just predicted
        if (typed_q.size() != 0)
        begin
            while (decoded_q.size() > mark)
                void'(decoded_q.pop_back());
            foreach (typed_q[i])
                queue_result(typed_q[i]);
            typed_q.delete();
        end
        beats_sent++;
    endtask

    // class count write: only once the pipe has drained
    task automatic write_class_count(input logic [CFG_W-1:0] value);
        @(negedge clk);
        s_axis_tvalid <= 1'b0;
        while (decoded_q.size() != 0)
            @(negedge clk);
        repeat (DRAIN_CYCLES) @(negedge clk);
        cfg_wdata <= value;
        cfg_we    <= 1'b1;
        @(negedge clk);
        cfg_we <= 1'b0;
        dec_classes = value;
    endtask

    // one sequence of frames with shaped scores; the last frame is sometimes cut by eos
    task automatic random_utterance();
        int unsigned n, frames, cut, span, peak, prev_peak, style, f, c;
        logic [SCORE_W-1:0] level, score;
        n = frame_length();
        if (n > 300)
        begin
            frames = 1;
            cut    = $urandom_range(1, 20);
        end
        else
        begin
            frames = (n > 12) ? 1 : $urandom_range(1, 8);
            cut    = ($urandom_range(0, 5) == 0) ? $urandom_range(1, n) : n;
        end
        prev_peak = 0;
        for (f = 0; f < frames; f++)
        begin
            span  = (f == frames - 1) ? cut : n;
            style = $urandom_range(0, 9);
            // repeating the last peak exercises repeat collapsing
            peak  = ($urandom_range(0, 2) == 0 && prev_peak < span) ? prev_peak
                                                                     : $urandom_range(0, span - 1);
            level = SCORE_W'($urandom_range(0, 65535));
            for (c = 0; c < span; c++)
            begin
                case (style)
                    0:       score = '0;            // silent frame, blank wins
                    1:       score = level;         // flat frame, ties keep class 0
                    2, 3:    score = SCORE_W'($urandom_range(0, 65535));
                    default: score = (c == peak) ? (($urandom_range(0, 3) == 0) ? SCORE_MAX
                                                    : SCORE_W'($urandom_range(4096, 65535)))
                                                 : SCORE_W'($urandom_range(0, 4095));
                endcase
                push_score(score, f == frames - 1 && c == span - 1);
            end
            prev_peak = peak;
        end
    endtask

    // result checker: every accepted result against the oldest prediction
    always @(posedge clk)
    begin : result_check
        decode_result_t seen;
        decode_result_t want;
        if (rst_n && m_axis_tvalid && m_axis_tready)
        begin
            seen.kind          = m_axis_tuser[0];
            seen.class_index   = m_axis_tdata[0 +: INDEX_W];
            seen.char_score    = m_axis_tdata[SCORE_LO +: SCORE_W];
            seen.average_score = m_axis_tdata[AVG_LO +: SCORE_W];
            seen.char_count    = m_axis_tdata[COUNT_LO +: COUNT_W];
            seen.last          = m_axis_tlast;
            if (seen.kind == KIND_SUMMARY)
                summaries_checked++;
            else
                chars_checked++;
            if (decoded_q.size() == 0)
                note_failure({"result with nothing pending: ", show(seen)});
            else
            begin
                want = decoded_q.pop_front();
                if (seen.kind !== want.kind || seen.class_index !== want.class_index ||
                    seen.char_score !== want.char_score ||
                    seen.average_score !== want.average_score ||
                    seen.char_count !== want.char_count || seen.last !== want.last)
                    note_failure({"mismatch: expected ", show(want), " got ", show(seen)});
            end
        end
    end

    // receiver: random stall bursts, none in the tail
    always @(negedge clk)
    begin
        if (hold_off)
            m_axis_tready <= 1'b0;
        else if (ready_gap != 0)
        begin
            m_axis_tready <= 1'b0;
            ready_gap     <= ready_gap - 1;
        end
        else if (!quiet_tail && $urandom_range(0, 7) == 0)
        begin
            m_axis_tready <= 1'b0;
            ready_gap     <= $urandom_range(0, 9);
        end
        else
            m_axis_tready <= 1'b1;
    end

    // long receiver hold-off while scores keep coming, so the job queue fills
    // and the decoder has to stall its input
    initial
    begin : long_hold
        wait (hold_request);
        @(negedge clk);
        hold_off <= 1'b1;
        repeat (HOLD_CYCLES) @(negedge clk);
        hold_off <= 1'b0;
    end

    initial
    begin : stimulus
        int unsigned pick, random_base;
        logic [CFG_W-1:0] classes;
        clk           = 1'b0;
        rst_n         = 1'b0;
        cfg_we        = 1'b0;
        cfg_wdata     = '0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata  = '0;
        s_axis_tlast  = 1'b0;
        m_axis_tready = 1'b0;
        dec_classes   = CFG_W'(RESET_CLASSES);
        clear_utterance();

        // directed table
        // reset class count: partial frames closed by eos
        add_row('{ROW_SCORE, 16'd0, 1'b1, 2'd1,
                  summary_result(16'd0, 11'd0), NO_RESULT});
        add_row('{ROW_SCORE, 16'hFFFF, 1'b0, 2'd0, NO_RESULT, NO_RESULT});
        // tie at full scale keeps the blank
        add_row('{ROW_SCORE, 16'hFFFF, 1'b1, 2'd1,
                  summary_result(16'd0, 11'd0), NO_RESULT});
        add_row('{ROW_SCORE, 16'd0, 1'b0, 2'd0, NO_RESULT, NO_RESULT});
        add_row('{ROW_SCORE, 16'hFFFF, 1'b1, 2'd2,
                  char_result(13'd1, 16'hFFFF, 1'b0),
                  summary_result(16'hFFFF, 11'd1)});
        // zero acts as the minimum of two classes
        add_row('{ROW_WRITE, 16'd0, 1'b0, 2'd0, NO_RESULT, NO_RESULT});
        add_row('{ROW_SCORE, 16'd1, 1'b0, 2'd0, NO_RESULT, NO_RESULT});
        add_row('{ROW_SCORE, 16'd2, 1'b0, 2'd1,
                  char_result(13'd1, 16'd2, 1'b1), NO_RESULT});
        add_row('{ROW_SCORE, 16'd5, 1'b0, 2'd0, NO_RESULT, NO_RESULT});
        add_row('{ROW_SCORE, 16'd3, 1'b0, 2'd0, NO_RESULT, NO_RESULT});
        add_row('{ROW_SCORE, 16'd0, 1'b0, 2'd0, NO_RESULT, NO_RESULT});
        add_row('{ROW_SCORE, 16'd7, 1'b0, 2'd0, NO_RESULT, NO_RESULT});
        add_row('{ROW_SCORE, 16'd0, 1'b0, 2'd0, NO_RESULT, NO_RESULT});
        // repeat of class 1 collapses; average floor(9 / 2)
        add_row('{ROW_SCORE, 16'd9, 1'b1, 2'd1,
                  summary_result(16'd4, 11'd2), NO_RESULT});
        add_row('{ROW_WRITE, 16'd1, 1'b0, 2'd0, NO_RESULT, NO_RESULT});
        add_row('{ROW_SCORE, 16'd0, 1'b0, 2'd0, NO_RESULT, NO_RESULT});
        add_row('{ROW_SCORE, 16'd0, 1'b0, 2'd0, NO_RESULT, NO_RESULT});
        add_row('{ROW_SCORE, 16'd100, 1'b1, 2'd1,
                  summary_result(16'd0, 11'd0), NO_RESULT});
        // all ones acts as the maximum class count
        add_row('{ROW_WRITE, 16'd16383, 1'b0, 2'd0, NO_RESULT, NO_RESULT});
        add_row('{ROW_SCORE, 16'd0, 1'b0, 2'd0, NO_RESULT, NO_RESULT});
        add_row('{ROW_SCORE, 16'h8000, 1'b0, 2'd0, NO_RESULT, NO_RESULT});
        add_row('{ROW_SCORE, 16'hFFFF, 1'b1, 2'd2,
                  char_result(13'd2, 16'hFFFF, 1'b0),
                  summary_result(16'hFFFF, 11'd1)});
        // shrink the frame while two classes in: next beat closes it
        add_row('{ROW_WRITE, 16'd5, 1'b0, 2'd0, NO_RESULT, NO_RESULT});
        add_row('{ROW_SCORE, 16'd10, 1'b0, 2'd0, NO_RESULT, NO_RESULT});
        add_row('{ROW_SCORE, 16'd20, 1'b0, 2'd0, NO_RESULT, NO_RESULT});
        add_row('{ROW_WRITE, 16'd2, 1'b0, 2'd0, NO_RESULT, NO_RESULT});
        add_row('{ROW_SCORE, 16'd30, 1'b0, 2'd0, NO_RESULT, NO_RESULT});
        add_row('{ROW_SCORE, 16'd40, 1'b1, 2'd0, NO_RESULT, NO_RESULT});
        add_row('{ROW_WRITE, 16'd8192, 1'b0, 2'd0, NO_RESULT, NO_RESULT});
        add_row('{ROW_SCORE, 16'd300, 1'b0, 2'd0, NO_RESULT, NO_RESULT});
        add_row('{ROW_SCORE, 16'hFFFF, 1'b1, 2'd0, NO_RESULT, NO_RESULT});

        repeat (RESET_CYCLES) @(negedge clk);
        rst_n <= 1'b1;

        foreach (directed_rows[i])
        begin
            if (directed_rows[i].kind == ROW_WRITE)
                write_class_count(directed_rows[i].value[CFG_W-1:0]);
            else
            begin
                if (directed_rows[i].typed_n >= 1)
                    typed_q = {typed_q, directed_rows[i].typed_a};
                if (directed_rows[i].typed_n >= 2)
                    typed_q = {typed_q, directed_rows[i].typed_b};
                push_score(directed_rows[i].value, directed_rows[i].eos);
            end
        end

        // random phases, each with its own class count
        random_base = beats_sent;
        while (beats_sent - random_base < RANDOM_BEATS)
        begin
            if (beats_sent - random_base >= RANDOM_BEATS - QUIET_BEATS)
            begin
                quiet_tail   = 1'b1;
                sender_idles = 1'b0;
            end
            else
                sender_idles = ($urandom_range(0, 3) != 0);
            pick = $urandom_range(0, 9);
            case (pick)
                0:       classes = CFG_W'($urandom_range(0, 1));
                1:       classes = ($urandom_range(0, 1) == 0) ? CFG_W'(MAX_CLASSES)
                                                   : CFG_W'($urandom_range(8193, 16383));
                2:       classes = CFG_W'($urandom_range(13, 40));
                default: classes = CFG_W'($urandom_range(2, 12));
            endcase
            write_class_count(classes);
            if (beats_sent - random_base >= 100)
                hold_request = 1'b1;
            repeat ($urandom_range(1, 4)) random_utterance();
        end

        @(negedge clk);
        s_axis_tvalid <= 1'b0;
        while (decoded_q.size() != 0)
            @(negedge clk);
        repeat (DRAIN_CYCLES) @(negedge clk);

        $display("%0d score beats sent; %0d characters and %0d summaries compared",
                 beats_sent, chars_checked, summaries_checked);
        $display("%s", {"class counts from below minimum to above maximum, mid-frame ",
                        "writes, eos-cut frames, repeats, blanks and a long output stall"});
        if (failures == 0)
            $display("tb_ctc_greedy_decoder_core OK");
        else
        begin
            $display("%0d failures", failures);
            $display("tb_ctc_greedy_decoder_core NOT OK");
        end
        $finish;
    end

endmodule
